// ----- hdl/i2cms_pkg.sv -----
// Shared types and codes for the I2C master transfer sequencer.
package i2cms_pkg;

    // Command codes of a request word.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    // Bus event codes.
    localparam logic [3:0] EV_START_SENT = 4'd0;
    localparam logic [3:0] EV_WADDR_ACK  = 4'd1;
    localparam logic [3:0] EV_WADDR_NACK = 4'd2;
    localparam logic [3:0] EV_DATA_ACK   = 4'd3;
    localparam logic [3:0] EV_DATA_NACK  = 4'd4;
    localparam logic [3:0] EV_RADDR_ACK  = 4'd5;
    localparam logic [3:0] EV_RADDR_NACK = 4'd6;
    localparam logic [3:0] EV_RX_ACK     = 4'd7;
    localparam logic [3:0] EV_RX_NACK    = 4'd8;

    // Bus actions.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_ADDR    = 3'd2;
    localparam logic [2:0] ACT_DATA    = 3'd3;
    localparam logic [2:0] ACT_RX_ACK  = 3'd4;
    localparam logic [2:0] ACT_RX_NACK = 3'd5;
    localparam logic [2:0] ACT_STOP    = 3'd6;

    // Transfer modes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    // Transfer status codes.
    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [7:0] NACK_SAT       = 8'hFF;
    localparam logic [7:0] NACK_TRIES_RST = 8'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       read_mode;
        logic [6:0] slave_address;
        logic [7:0] transfer_length;
        logic [7:0] buffer_index;
        logic [7:0] data_byte;
        logic [3:0] bus_status;
        logic [7:0] bus_byte_in;
    } req_word_t;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] bus_byte_out;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic [1:0] transfer_status;
    } rsp_word_t;

    // Decided result of one word; the data byte may still come from the buffer.
    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] bus_byte_out;
        logic       use_ram;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic [1:0] transfer_status;
    } entry_t;

endpackage

// ----- hdl/i2cms_ram.sv -----
// Generic single-port RAM with registered read.
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/i2cms_seq.sv -----
// Transfer state registers and the decision logic for each accepted word.
module i2cms_seq #(
    parameter int BUFFER_DEPTH = 256,
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data,
    input  logic                 accept,
    input  i2cms_pkg::req_word_t req,
    output logic [AW-1:0]        ram_addr,
    output logic                 ram_we,
    output logic [7:0]           ram_wdata,
    output logic                 ram_re,
    output i2cms_pkg::entry_t    entry
);

    // Reciprocal of the depth, exact for every 8-bit index.
    localparam int RECIP_INT = (65536 + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
    localparam logic [16:0] RECIP = 17'(RECIP_INT);
    localparam logic [7:0]  DEPTH_M = 8'(BUFFER_DEPTH - 1);

    logic [1:0] mode_reg,   mode_next;
    logic [6:0] addr_reg,   addr_next;
    logic [7:0] idx_reg,    idx_next;
    logic [7:0] count_reg,  count_next;
    logic [7:0] nack_reg,   nack_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] tries_reg;

    logic [7:0]  nack_inc;
    logic [7:0]  send_idx;
    logic [7:0]  idx_src;
    logic [24:0] recip_prod;
    logic [15:0] quot_depth;
    logic [7:0]  idx_mod;
    logic        want_addr, want_send, want_req, want_stop, want_err;

    // Buffer position modulo the depth.
    always_comb
    begin
        idx_src    = (req.command == i2cms_pkg::CMD_LOAD) ? req.buffer_index : send_idx;
        recip_prod = 25'(idx_src) * 25'(RECIP);
        quot_depth = 16'(recip_prod[23:16]) * 16'(DEPTH_M + 8'd1);
        idx_mod    = idx_src - quot_depth[7:0];
    end

    assign ram_addr  = idx_mod[AW-1:0];
    assign ram_wdata = req.data_byte;

    always_comb
    begin
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        nack_next   = nack_reg;
        status_next = status_reg;
        entry       = '0;
        ram_we      = 1'b0;
        send_idx    = idx_reg;
        nack_inc    = (nack_reg == i2cms_pkg::NACK_SAT) ? nack_reg : nack_reg + 8'd1;
        want_addr   = 1'b0;
        want_send   = 1'b0;
        want_req    = 1'b0;
        want_stop   = 1'b0;
        want_err    = 1'b0;

        unique case (req.command)
            i2cms_pkg::CMD_LOAD:
            begin
                ram_we = accept;
            end
            i2cms_pkg::CMD_START:
            begin
                addr_next        = req.slave_address;
                mode_next        = req.read_mode ? i2cms_pkg::MODE_RX : i2cms_pkg::MODE_TX;
                count_next       = req.transfer_length;
                idx_next         = 8'd0;
                status_next      = i2cms_pkg::ST_BUSY;
                entry.bus_action = i2cms_pkg::ACT_START;
            end
            i2cms_pkg::CMD_EVENT:
            begin
                unique case (req.bus_status)
                    i2cms_pkg::EV_START_SENT:
                    begin
                        nack_next = 8'd0;
                        want_addr = 1'b1;
                    end
                    i2cms_pkg::EV_WADDR_ACK, i2cms_pkg::EV_DATA_ACK:
                    begin
                        nack_next = 8'd0;
                        want_send = 1'b1;
                    end
                    i2cms_pkg::EV_WADDR_NACK, i2cms_pkg::EV_RADDR_NACK:
                    begin
                        nack_next = nack_inc;
                        want_addr = 1'b1;
                    end
                    i2cms_pkg::EV_DATA_NACK:
                    begin
                        nack_next = nack_inc;
                        if (nack_inc < tries_reg)
                        begin
                            send_idx  = idx_reg - 8'd1;
                            want_send = 1'b1;
                        end
                        else
                        begin
                            want_err = 1'b1;
                        end
                    end
                    i2cms_pkg::EV_RADDR_ACK:
                    begin
                        nack_next = 8'd0;
                        want_req  = 1'b1;
                    end
                    i2cms_pkg::EV_RX_ACK:
                    begin
                        entry.rx_valid = 1'b1;
                        entry.rx_index = idx_reg;
                        entry.rx_byte  = req.bus_byte_in;
                        send_idx       = idx_reg + 8'd1;
                        idx_next       = idx_reg + 8'd1;
                        want_req       = 1'b1;
                    end
                    i2cms_pkg::EV_RX_NACK:
                    begin
                        entry.rx_valid = 1'b1;
                        entry.rx_index = idx_reg;
                        entry.rx_byte  = req.bus_byte_in;
                        want_stop      = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (want_addr)
        begin
            if (nack_next >= tries_reg)
            begin
                want_err = 1'b1;
            end
            else if (mode_reg == i2cms_pkg::MODE_TX)
            begin
                entry.bus_action   = i2cms_pkg::ACT_ADDR;
                entry.bus_byte_out = {addr_reg, 1'b0};
            end
            else if (mode_reg == i2cms_pkg::MODE_RX)
            begin
                entry.bus_action   = i2cms_pkg::ACT_ADDR;
                entry.bus_byte_out = {addr_reg, 1'b1};
            end
            else
            begin
                want_err = 1'b1;
            end
        end

        if (want_send)
        begin
            if (send_idx < count_reg)
            begin
                entry.bus_action = i2cms_pkg::ACT_DATA;
                entry.use_ram    = 1'b1;
                idx_next         = send_idx + 8'd1;
            end
            else
            begin
                want_stop = 1'b1;
            end
        end

        if (want_req)
        begin
            entry.bus_action = ({1'b0, send_idx} + 9'd1 < {1'b0, count_reg}) ?
                               i2cms_pkg::ACT_RX_ACK : i2cms_pkg::ACT_RX_NACK;
        end

        if (want_stop)
        begin
            entry.bus_action = i2cms_pkg::ACT_STOP;
            status_next      = i2cms_pkg::ST_DONE;
        end

        if (want_err)
        begin
            entry.bus_action = i2cms_pkg::ACT_NONE;
            status_next      = i2cms_pkg::ST_ERROR;
        end

        // Stop and error both drop the transfer and clear the buffer index but keep the length and NACK counts.
        if (want_stop || want_err)
        begin
            mode_next = i2cms_pkg::MODE_NONE;
            addr_next = 7'd0;
            idx_next  = 8'd0;
        end

        entry.transfer_status = status_next;
    end

    assign ram_re = accept && entry.use_ram;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= i2cms_pkg::MODE_NONE;
            addr_reg   <= 7'd0;
            idx_reg    <= 8'd0;
            count_reg  <= 8'd0;
            nack_reg   <= 8'd0;
            status_reg <= i2cms_pkg::ST_READY;
            tries_reg  <= i2cms_pkg::NACK_TRIES_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                tries_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg   <= mode_next;
                addr_reg   <= addr_next;
                idx_reg    <= idx_next;
                count_reg  <= count_next;
                nack_reg   <= nack_next;
                status_reg <= status_next;
            end
        end
    end

endmodule

// ----- hdl/i2cms_outq.sv -----
// Two-entry result queue that merges buffer read data into the response word.
module i2cms_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i2cms_pkg::entry_t    entry,
    input  logic [7:0]           ram_q,
    output logic                 full,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output i2cms_pkg::rsp_word_t rsp_word
);

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    i2cms_pkg::entry_t    s1_reg;
    i2cms_pkg::rsp_word_t s2_reg, s2_next;
    logic                 move;

    // The first stage moves on whenever the output register is free or taken.
    assign move = s1_valid_reg && (!s2_valid_reg || !rsp_stall);
    assign full = s1_valid_reg && s2_valid_reg && rsp_stall;

    always_comb
    begin
        s2_next.bus_action      = s1_reg.bus_action;
        s2_next.bus_byte_out    = s1_reg.use_ram ? ram_q : s1_reg.bus_byte_out;
        s2_next.rx_valid        = s1_reg.rx_valid;
        s2_next.rx_index        = s1_reg.rx_index;
        s2_next.rx_byte         = s1_reg.rx_byte;
        s2_next.transfer_status = s1_reg.transfer_status;

        s1_valid_next = push || (s1_valid_reg && !move);
        s2_valid_next = move || (s2_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_reg <= entry;
        end
        if (move)
        begin
            s2_reg <= s2_next;
        end
    end

    assign rsp_valid = s2_valid_reg;
    assign rsp_word  = s2_reg;

endmodule

// ----- hdl/i2c_master_transfer_sequencer_top.sv -----
// Top level of the I2C master transfer sequencer.
// A response word is registered in the queue's first stage, then in its output register.
// Throughput: one request word per cycle while req_stall is low; the transmit buffer RAM
// is read in the accept cycle; its registered data enters the response at the output.
// Reset clears the transfer state, the queue and the NACK limit (to 3) at once;
// the transmit buffer is not cleared and holds unknown data until loaded.
module i2c_master_transfer_sequencer_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  i2cms_pkg::req_word_t req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output i2cms_pkg::rsp_word_t rsp_word,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic              accept;
    logic              queue_full;
    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_q;
    i2cms_pkg::entry_t entry;

    // A word is taken unless both queue stages hold results and the output is stalled.
    assign req_stall = queue_full;
    assign accept    = req_valid && !queue_full;

    // The sequencer decides the bus action for each word and drives the buffer port.
    i2cms_seq #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .req      (req_word),
        .ram_addr (ram_addr),
        .ram_we   (ram_we),
        .ram_wdata(ram_wdata),
        .ram_re   (ram_re),
        .entry    (entry)
    );

    // Transmit buffer: at most one write or one read per accepted word.
    i2cms_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_txbuf (
        .clk  (clk),
        .addr (ram_addr),
        .we   (ram_we),
        .wdata(ram_wdata),
        .re   (ram_re),
        .rdata(ram_q)
    );

    // The result queue picks up the read data and decouples the output stall.
    i2cms_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .entry    (entry),
        .ram_q    (ram_q),
        .full     (queue_full),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

endmodule
